/* rtl/gaam_pkg.sv */
package gaam_pkg;

	localparam int unsigned MvW     = 14;
	localparam int unsigned AngleW  = 13;
	localparam int unsigned VoltW   = 8;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned SettleW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam int unsigned SpanW = MvW + 1;
	localparam int unsigned NumW  = 29;
	localparam int unsigned MagW  = NumW - 1;
	localparam int unsigned CntW  = $clog2(MagW);

	localparam logic [MvW-1:0]     RstClosedInput = MvW'(560);
	localparam logic [MvW-1:0]     RstOpenInput   = MvW'(10000);
	localparam logic [AngleW-1:0]  RstClosedAngle = AngleW'(600);
	localparam logic [AngleW-1:0]  RstOpenAngle   = AngleW'(0);
	localparam logic [MvW-1:0]     RstDeadThresh  = MvW'(200);
	localparam logic [VoltW-1:0]   RstMinSupply   = VoltW'(24);
	localparam logic [SettleW-1:0] RstSettle      = SettleW'(3000);

	typedef enum logic [1:0] {
		DEC_MAPPED      = 2'd0,
		DEC_LOW_SUPPLY  = 2'd1,
		DEC_SETTLING    = 2'd2,
		DEC_BELOW_DEAD  = 2'd3
	} decision_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CLOSED_INPUT = 3'd0,
		REG_OPEN_INPUT   = 3'd1,
		REG_CLOSED_ANGLE = 3'd2,
		REG_OPEN_ANGLE   = 3'd3,
		REG_DEAD_THRESH  = 3'd4,
		REG_MIN_SUPPLY   = 3'd5,
		REG_SETTLE       = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic div;
		logic fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mapped;
	} status_t;

endpackage

/* rtl/gaam_ctrl.sv */
module gaam_ctrl
	import gaam_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = status.mapped ? ST_SUM : ST_DONE;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CntW'(MagW - 1)) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/gaam_dp.sv */
module gaam_dp
	import gaam_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic                       cfg_we,
	input  logic [CfgIdxW-1:0]         cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data,
	input  logic [MvW-1:0]             analog_mv,
	input  logic [VoltW-1:0]           supply_volts,
	input  logic [TimeW-1:0]           time_ms,
	output logic signed [AngleW-1:0]   angle_mrad,
	output logic                       tracking,
	output logic [1:0]                 decision
);

	logic [MvW-1:0]            closed_in_q, open_in_q, dead_q;
	logic signed [AngleW-1:0]  closed_ang_q, open_ang_q;
	logic [VoltW-1:0]          min_supply_q;
	logic [SettleW-1:0]        settle_q;

	logic [VoltW-1:0]          last_supply_q;
	logic [TimeW-1:0]          stamp_q;
	logic                      present_q;
	logic signed [AngleW-1:0]  held_q;
	logic                      ever_q;

	logic [MvW-1:0]            a_q;
	decision_t                 dec_q;
	logic signed [NumW-1:0]    prod1_q, prod2_q;
	logic signed [SpanW-1:0]   span_q;
	logic                      neg_q;
	logic [MvW-1:0]            dvs_q;
	logic [MagW-1:0]           quo_q;
	logic [MvW-1:0]            rem_q;

	logic signed [AngleW-1:0]  angle_out_q;
	logic                      tracking_q;
	decision_t                 dec_out_q;

	logic                      rise, present_eff, settling;
	logic [TimeW-1:0]          stamp_eff, since;
	decision_t                 dec_new;
	logic signed [SpanW-1:0]   span, diff_a;
	logic signed [AngleW:0]    dang;
	logic signed [NumW-1:0]    num, q_signed, pos, lo, hi, clamped;
	logic [MagW-1:0]           num_mag;
	logic [MvW:0]              rem_sh, rem_sub;
	logic                      take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_in_q  <= RstClosedInput;
			open_in_q    <= RstOpenInput;
			closed_ang_q <= RstClosedAngle;
			open_ang_q   <= RstOpenAngle;
			dead_q       <= RstDeadThresh;
			min_supply_q <= RstMinSupply;
			settle_q     <= RstSettle;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOSED_INPUT: closed_in_q  <= cfg_data[MvW-1:0];
				REG_OPEN_INPUT:   open_in_q    <= cfg_data[MvW-1:0];
				REG_CLOSED_ANGLE: closed_ang_q <= cfg_data[AngleW-1:0];
				REG_OPEN_ANGLE:   open_ang_q   <= cfg_data[AngleW-1:0];
				REG_DEAD_THRESH:  dead_q       <= cfg_data[MvW-1:0];
				REG_MIN_SUPPLY:   min_supply_q <= cfg_data[VoltW-1:0];
				REG_SETTLE:       settle_q     <= cfg_data[SettleW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign rise        = (last_supply_q < min_supply_q) && (supply_volts >= min_supply_q);
	assign present_eff = present_q || rise;
	assign stamp_eff   = rise ? time_ms : stamp_q;
	assign since       = time_ms - stamp_eff;
	assign settling    = present_eff && (since < TimeW'(settle_q));

	always_comb begin
		if (supply_volts < min_supply_q) begin
			dec_new = DEC_LOW_SUPPLY;
		end else if (settling) begin
			dec_new = DEC_SETTLING;
		end else if (analog_mv < dead_q) begin
			dec_new = DEC_BELOW_DEAD;
		end else begin
			dec_new = DEC_MAPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_supply_q <= '0;
			stamp_q       <= '0;
			present_q     <= 1'b0;
			held_q        <= '0;
			ever_q        <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_supply_q <= supply_volts;
				if (rise) begin
					stamp_q   <= time_ms;
					present_q <= 1'b1;
				end
			end
			if (cmd.fix) begin
				held_q <= clamped[AngleW-1:0];
				ever_q <= 1'b1;
			end
		end
	end

	assign span   = $signed({1'b0, open_in_q}) - $signed({1'b0, closed_in_q});
	assign diff_a = $signed({1'b0, a_q}) - $signed({1'b0, closed_in_q});
	assign dang   = $signed({open_ang_q[AngleW-1], open_ang_q})
		- $signed({closed_ang_q[AngleW-1], closed_ang_q});

	assign num     = prod1_q + prod2_q;
	assign num_mag = num[NumW-1] ? MagW'(-num) : num[MagW-1:0];

	assign rem_sh  = {rem_q, quo_q[MagW-1]};
	assign take    = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign pos      = (span_q == '0) ? NumW'(closed_ang_q) : q_signed;
	assign lo       = (closed_ang_q < open_ang_q) ? NumW'(closed_ang_q) : NumW'(open_ang_q);
	assign hi       = (closed_ang_q < open_ang_q) ? NumW'(open_ang_q) : NumW'(closed_ang_q);

	always_comb begin
		clamped = pos;
		if (pos < lo) begin
			clamped = lo;
		end
		if (pos > hi) begin
			clamped = hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= analog_mv;
			dec_q <= dec_new;
		end
		if (cmd.mul) begin
			prod1_q <= NumW'(closed_ang_q) * NumW'(span);
			prod2_q <= NumW'(diff_a) * NumW'(dang);
			span_q  <= span;
		end
		if (cmd.sum) begin
			quo_q <= num_mag;
			rem_q <= '0;
			dvs_q <= span_q[SpanW-1] ? MvW'(-span_q) : span_q[MvW-1:0];
			neg_q <= num[NumW-1] ^ span_q[SpanW-1];
		end
		if (cmd.div) begin
			rem_q <= take ? rem_sub[MvW-1:0] : rem_sh[MvW-1:0];
			quo_q <= {quo_q[MagW-2:0], take};
		end
		if (cmd.out_load) begin
			angle_out_q <= ever_q ? held_q : closed_ang_q;
			tracking_q  <= (dec_q == DEC_MAPPED);
			dec_out_q   <= dec_q;
		end
	end

	assign status.mapped = (dec_q == DEC_MAPPED);
	assign angle_mrad    = angle_out_q;
	assign tracking      = tracking_q;
	assign decision      = dec_out_q;

endmodule

/* rtl/gated_analog_to_angle_mapper_unit.sv */
// Gated analog-to-angle mapper. Each sensor sample (analog_mv, supply_volts,
// time_ms) yields one result: the held joint angle, a tracking flag and the
// decision code (mapped, supply too low, settling, below dead threshold).
// One sample is in work at a time. A held sample goes from the multiply state to
// the done state; a mapped sample also passes sum, the 28-step restoring divider
// that forms the interpolated angle, and the clamp. A finished result waits in the
// output register while the next sample is accepted. Configuration writes via the
// cfg channel are always accepted and must be issued only while the unit is idle.
module gated_analog_to_angle_mapper_unit
	import gaam_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [MvW-1:0]            analog_mv,
	input  logic [VoltW-1:0]          supply_volts,
	input  logic [TimeW-1:0]          time_ms,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [AngleW-1:0]  angle_mrad,
	output logic                      tracking,
	output logic [1:0]                decision,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	gaam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gaam_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.analog_mv    (analog_mv),
		.supply_volts (supply_volts),
		.time_ms      (time_ms),
		.angle_mrad   (angle_mrad),
		.tracking     (tracking),
		.decision     (decision)
	);

endmodule

/* rtl/gaam_checker.sv */
module gaam_checker
	import gaam_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [AngleW-1:0]  angle_mrad,
	input logic                      tracking,
	input logic [1:0]                decision,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle_mrad)
			&& $stable(tracking) && $stable(decision))
		else $error("result changed while stalled");

	a_track_dec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tracking == (decision == DEC_MAPPED)))
		else $error("tracking flag disagrees with decision");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
		else $error("result appeared one cycle after accept");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction stalled");

endmodule

bind gated_analog_to_angle_mapper_unit gaam_checker u_gaam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.angle_mrad (angle_mrad),
	.tracking   (tracking),
	.decision   (decision),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

/* dv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gaam_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int StallCycles = 300;
	localparam int DrainCycles = 40;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct {
		logic [MvW-1:0]   mv;
		logic [VoltW-1:0] volts;
		logic [TimeW-1:0] stamp;
	} sample_t;

	typedef struct {
		logic signed [AngleW-1:0] angle;
		logic                     tracking;
		decision_t                decision;
	} angle_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [MvW-1:0]           analog_mv = '0;
	logic [VoltW-1:0]         supply_volts = '0;
	logic [TimeW-1:0]         time_ms = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [AngleW-1:0] angle_mrad;
	logic                     tracking;
	logic [1:0]               decision;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CfgIdxW-1:0]       cfg_index = '0;
	logic [CfgDataW-1:0]      cfg_data = '0;

	gated_analog_to_angle_mapper_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.analog_mv    (analog_mv),
		.supply_volts (supply_volts),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.angle_mrad   (angle_mrad),
		.tracking     (tracking),
		.decision     (decision),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// mapper configuration and state as the testbench tracks it
	logic [MvW-1:0]           cfg_closed_in  = RstClosedInput;
	logic [MvW-1:0]           cfg_open_in    = RstOpenInput;
	logic signed [AngleW-1:0] cfg_closed_ang = RstClosedAngle;
	logic signed [AngleW-1:0] cfg_open_ang   = RstOpenAngle;
	logic [MvW-1:0]           cfg_dead       = RstDeadThresh;
	logic [VoltW-1:0]         cfg_min_supply = RstMinSupply;
	logic [SettleW-1:0]       cfg_settle     = RstSettle;

	logic signed [AngleW-1:0] kept_angle = '0;
	logic                     have_fix = 1'b0;
	logic [VoltW-1:0]         prev_volts = '0;
	logic [TimeW-1:0]         power_stamp = '0;
	logic                     power_stamp_set = 1'b0;

	sample_t       sample_backlog[$];
	angle_report_t due_reports[$];

	int  offered = 0;
	int  accepted = 0;
	int  cfg_writes = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  sender_hold = 1'b0;
	int  stall_req = 0;
	int  stall_ack = 0;
	int  stall_left = 0;

	logic [TimeW-1:0] gen_time = '0;
	bit               gen_powered = 1'b1;

	function automatic angle_report_t step_mapper(sample_t s);
		angle_report_t r;
		logic [TimeW-1:0] since_on;
		longint ca, oa, ic, span, pos, lo, hi;
		if (prev_volts < cfg_min_supply && s.volts >= cfg_min_supply) begin
			power_stamp = s.stamp;
			power_stamp_set = 1'b1;
		end
		prev_volts = s.volts;
		since_on = s.stamp - power_stamp;
		if (s.volts < cfg_min_supply) begin
			r.decision = DEC_LOW_SUPPLY;
		end else if (power_stamp_set && since_on < TimeW'(cfg_settle)) begin
			r.decision = DEC_SETTLING;
		end else if (s.mv < cfg_dead) begin
			r.decision = DEC_BELOW_DEAD;
		end else begin
			ca = cfg_closed_ang;
			oa = cfg_open_ang;
			ic = longint'(cfg_closed_in);
			span = longint'(cfg_open_in) - ic;
			pos = ca;
			if (span != 0) begin
				pos = (ca * span + (longint'(s.mv) - ic) * (oa - ca)) / span;
			end
			lo = (ca < oa) ? ca : oa;
			hi = (ca < oa) ? oa : ca;
			if (pos < lo) begin
				pos = lo;
			end
			if (pos > hi) begin
				pos = hi;
			end
			kept_angle = AngleW'(pos);
			have_fix = 1'b1;
			r.decision = DEC_MAPPED;
		end
		r.tracking = (r.decision == DEC_MAPPED);
		r.angle = have_fix ? kept_angle : cfg_closed_ang;
		return r;
	endfunction

	task automatic note_mismatch(string what, longint want, longint got);
		mismatches++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endtask

	// monitor: configuration, input and output transactions
	always @(posedge clk) begin : watch_ports
		sample_t       cur;
		angle_report_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLOSED_INPUT: cfg_closed_in  = cfg_data[MvW-1:0];
					REG_OPEN_INPUT:   cfg_open_in    = cfg_data[MvW-1:0];
					REG_CLOSED_ANGLE: cfg_closed_ang = cfg_data[AngleW-1:0];
					REG_OPEN_ANGLE:   cfg_open_ang   = cfg_data[AngleW-1:0];
					REG_DEAD_THRESH:  cfg_dead       = cfg_data[MvW-1:0];
					REG_MIN_SUPPLY:   cfg_min_supply = cfg_data[VoltW-1:0];
					REG_SETTLE:       cfg_settle     = cfg_data[SettleW-1:0];
					default: ;
				endcase
				cfg_writes++;
			end
			if (in_valid && in_ready) begin
				cur.mv = analog_mv;
				cur.volts = supply_volts;
				cur.stamp = time_ms;
				due_reports.push_back(step_mapper(cur));
				accepted++;
			end
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: angle %0d tracking %0b decision %0d",
						$time, angle_mrad, tracking, decision);
				end else begin
					want = due_reports.pop_front();
					if (angle_mrad !== want.angle) begin
						note_mismatch("angle_mrad", want.angle, angle_mrad);
					end
					if (tracking !== want.tracking) begin
						note_mismatch("tracking", want.tracking, tracking);
					end
					if (decision !== want.decision) begin
						note_mismatch("decision", want.decision, decision);
					end
				end
			end
		end
	end

	// driver: hold an offered sample until its transaction completes
	always @(negedge clk) begin : drive_samples
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && accepted != offered) begin
		end else if (sample_backlog.size() != 0 && !sender_hold &&
				$urandom_range(99) >= send_idle_pct) begin
			s = sample_backlog.pop_front();
			analog_mv <= s.mv;
			supply_volts <= s.volts;
			time_ms <= s.stamp;
			in_valid <= 1'b1;
			offered++;
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (stall_req != stall_ack) begin
			stall_ack++;
			stall_left = StallCycles;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == CycleLimit) begin
			$display("** gated_analog_to_angle_mapper_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
		int seen;
		int width;
		int mask;
		case (idx)
			REG_CLOSED_ANGLE, REG_OPEN_ANGLE: width = AngleW;
			REG_MIN_SUPPLY:                  width = VoltW;
			REG_SETTLE:                      width = SettleW;
			default:                         width = MvW;
		endcase
		mask = (1 << width) - 1;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		// fill unused upper bits with noise
		cfg_data <= CfgDataW'(($urandom & ~mask) | (val & mask));
		while (cfg_writes == seen) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int ci, int oi, int ca, int oa, int dead, int minv, int settle);
		write_reg(REG_CLOSED_INPUT, ci);
		write_reg(REG_OPEN_INPUT, oi);
		write_reg(REG_CLOSED_ANGLE, ca);
		write_reg(REG_OPEN_ANGLE, oa);
		write_reg(REG_DEAD_THRESH, dead);
		write_reg(REG_MIN_SUPPLY, minv);
		write_reg(REG_SETTLE, settle);
	endtask

	task automatic push_sample(int mv, int volts, logic [TimeW-1:0] stamp);
		sample_t s;
		s.mv = MvW'(mv);
		s.volts = VoltW'(volts);
		s.stamp = stamp;
		sample_backlog.push_back(s);
	endtask

	task automatic wait_idle();
		while (!(sample_backlog.size() == 0 && accepted == offered &&
				due_reports.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	// mostly powered runs with advancing time; power drops, time jumps and noise mixed in
	task automatic queue_random(int n);
		sample_t s;
		int lo_mv, hi_mv, step_max, pick, minv, dead;
		lo_mv = (cfg_closed_in < cfg_open_in) ? int'(cfg_closed_in) : int'(cfg_open_in);
		hi_mv = (cfg_closed_in < cfg_open_in) ? int'(cfg_open_in) : int'(cfg_closed_in);
		step_max = int'(cfg_settle) / 6 + 20;
		minv = int'(cfg_min_supply);
		dead = int'(cfg_dead);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				gen_time = $urandom;
			end else if (pick < 5) begin
				gen_time = gen_time - $urandom_range(5000, 0);
			end else begin
				gen_time = gen_time + $urandom_range(step_max, 1);
			end
			if (gen_powered) begin
				gen_powered = ($urandom_range(99) >= 3);
			end else begin
				gen_powered = ($urandom_range(99) < 40);
			end
			if (pick >= 97) begin
				s.volts = VoltW'($urandom);
			end else if (gen_powered || minv == 0) begin
				s.volts = VoltW'($urandom_range(255, minv));
			end else begin
				s.volts = VoltW'($urandom_range(minv - 1, 0));
			end
			pick = $urandom_range(99);
			if (pick < 10) begin
				s.mv = (dead == 0) ? '0 : MvW'($urandom_range(dead - 1, 0));
			end else if (pick < 30) begin
				s.mv = MvW'($urandom);
			end else begin
				s.mv = MvW'($urandom_range(hi_mv, lo_mv));
			end
			s.stamp = gen_time;
			sample_backlog.push_back(s);
		end
	endtask

	initial begin : run_test
		int base;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 56;
		push_sample(5000, 0, 32'd100);
		push_sample(5000, 23, 32'd200);
		push_sample(5000, 24, 32'd1000);
		push_sample(5000, 255, 32'd3999);
		push_sample(0, 24, 32'd4000);
		push_sample(199, 30, 32'd4001);
		push_sample(200, 30, 32'd4002);
		push_sample(16383, 30, 32'd4003);
		push_sample(560, 30, 32'd4004);
		push_sample(10000, 30, 32'd4005);
		push_sample(5280, 30, 32'd4006);
		push_sample(5281, 30, 32'd4007);
		push_sample(7000, 10, 32'd4100);
		push_sample(7000, 24, 32'hFFFF_FF00);
		push_sample(7000, 24, 32'h0000_0100);
		push_sample(7000, 24, 32'h0000_0AB7);
		push_sample(7000, 24, 32'h0000_0AB8);
		push_sample(7000, 24, 32'hFFFF_F000);
		push_sample(16383, 255, 32'hFFFF_FFFF);
		push_sample(0, 255, 32'h0000_0000);
		gen_time = 32'd50000;
		queue_random(280);
		wait_idle();

		send_idle_pct = 56;
		recv_idle_pct = 26;
		write_reg(RegUnused, $urandom);
		set_config(0, 16383, -3142, 3142, 0, 1, 500);
		queue_random(280);
		wait_idle();

		// negative span, angles at the 13-bit extremes, no settle window
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(12000, 300, 4095, -4096, 1000, 255, 0);
		base = accepted;
		queue_random(250);
		while (accepted < base + 20) begin
			@(posedge clk);
		end
		stall_req++;
		while (accepted < base + 150) begin
			@(posedge clk);
		end
		sender_hold = 1'b1;
		while (!(accepted == offered && due_reports.size() == 0)) begin
			@(posedge clk);
		end
		@(posedge clk);
		sender_hold = 1'b0;
		wait_idle();

		// zero span
		set_config(8000, 8000, -1000, 2500, 16383, 0, 65535);
		push_sample(16383, 0, gen_time);
		push_sample(16382, 255, gen_time + 1);
		queue_random(100);
		wait_idle();

		repeat (3) begin
			set_config($urandom_range(16383, 0), $urandom_range(16383, 0),
				$urandom_range(8191, 0), $urandom_range(8191, 0),
				$urandom_range(4000, 0), $urandom_range(255, 0),
				$urandom_range(65535, 0));
			queue_random(80);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("** gated_analog_to_angle_mapper_unit: PASSED **");
		end else begin
			$display("** gated_analog_to_angle_mapper_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* gated_analog_to_angle_mapper_unit.f */
rtl/gaam_pkg.sv
rtl/gaam_ctrl.sv
rtl/gaam_dp.sv
rtl/gated_analog_to_angle_mapper_unit.sv
rtl/gaam_checker.sv
dv/tb_top.sv
